@@ design/cansd_pkg.sv @@
// Shared types, constants and helpers for the CAN signal decoder.
// No dependencies; every other design file imports this package.
package cansd_pkg;

  // Field widths
  localparam int unsigned IdW     = 29;
  localparam int unsigned LenW    = 4;
  localparam int unsigned DataW   = 64;
  localparam int unsigned BitW    = 6;
  localparam int unsigned RawW    = 32;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned ResultW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Frame limits
  localparam logic [LenW-1:0] MaxBytes = 4'd8;
  localparam logic [BitW-1:0] MaxField = 6'd32;

  // Stream payload widths (whole bytes)
  localparam int unsigned InTdataW  = 104;
  localparam int unsigned OutTdataW = 96;
  localparam int unsigned OutTuserW = 8;

  // Register reset values
  localparam logic [IdW-1:0]           RstSignalId    = '0;
  localparam logic [BitW-1:0]          RstStartBit    = '0;
  localparam logic [BitW-1:0]          RstFieldLength = 6'd8;
  localparam logic                     RstLittleEnd   = 1'b1;
  localparam logic                     RstSignedField = 1'b0;
  localparam logic signed [ScaleW-1:0] RstScaleFactor = 32'sd65536;
  localparam logic signed [ScaleW-1:0] RstScaleOffset = '0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIGNAL_ID     = 3'd0,
    CFG_START_BIT     = 3'd1,
    CFG_FIELD_LENGTH  = 3'd2,
    CFG_LITTLE_ENDIAN = 3'd3,
    CFG_SIGNED_FIELD  = 3'd4,
    CFG_SCALE_FACTOR  = 3'd5,
    CFG_SCALE_OFFSET  = 3'd6
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DECODED     = 2'd0,
    ST_ID_MISMATCH = 2'd1,
    ST_BAD_LENGTH  = 2'd2,
    ST_OUT_OF_FRAME = 2'd3
  } status_e;

  // Current signal description
  typedef struct packed {
    logic [IdW-1:0]           signal_id;
    logic [BitW-1:0]          first_bit;
    logic [BitW-1:0]          field_length;
    logic                     little_endian;
    logic                     signed_field;
    logic signed [ScaleW-1:0] scale_factor;
    logic signed [ScaleW-1:0] scale_offset;
  } cfg_t;

  // Reverse byte order of the data word; bit order inside each byte is kept
  function automatic logic [DataW-1:0] byte_swap(input logic [DataW-1:0] d);
    logic [DataW-1:0] r;
    for (int b = 0; b < DataW / 8; b++) begin
      r[b*8 +: 8] = d[(DataW/8 - 1 - b)*8 +: 8];
    end
    return r;
  endfunction

endpackage

@@ design/cansd_cfg_regs.sv @@
// Configuration register file of the CAN signal decoder.
// Depends on cansd_pkg for the register indexes and the cfg_t struct.
module cansd_cfg_regs import cansd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write transfer
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SIGNAL_ID:     cfg_d.signal_id     = cfg_data_i[IdW-1:0];
        CFG_START_BIT:     cfg_d.first_bit     = cfg_data_i[BitW-1:0];
        CFG_FIELD_LENGTH:  cfg_d.field_length  = cfg_data_i[BitW-1:0];
        CFG_LITTLE_ENDIAN: cfg_d.little_endian = cfg_data_i[0];
        CFG_SIGNED_FIELD:  cfg_d.signed_field  = cfg_data_i[0];
        CFG_SCALE_FACTOR:  cfg_d.scale_factor  = $signed(cfg_data_i[ScaleW-1:0]);
        CFG_SCALE_OFFSET:  cfg_d.scale_offset  = $signed(cfg_data_i[ScaleW-1:0]);
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // Hold registers, load defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signal_id     <= RstSignalId;
      cfg_q.first_bit     <= RstStartBit;
      cfg_q.field_length  <= RstFieldLength;
      cfg_q.little_endian <= RstLittleEnd;
      cfg_q.signed_field  <= RstSignedField;
      cfg_q.scale_factor  <= RstScaleFactor;
      cfg_q.scale_offset  <= RstScaleOffset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/cansd_extract.sv @@
// Field extraction: identifier/length/bounds checks and raw bit gather.
// Depends on cansd_pkg; purely combinational, fed from the input register.
module cansd_extract import cansd_pkg::*; (
  input  cfg_t                 cfg_i,
  input  logic [IdW-1:0]       frame_id_i,
  input  logic [LenW-1:0]      frame_length_i,
  input  logic [DataW-1:0]     frame_data_i,
  output status_e              status_o,
  output logic [RawW-1:0]      raw_o,
  output logic signed [RawW:0] value_o
);

  logic [LenW-1:0]  nbytes;
  logic [6:0]       nbits;
  logic [6:0]       intel_end;
  logic [6:0]       moto_first;
  logic [6:0]       moto_last;
  logic [6:0]       moto_shamt;
  logic [BitW-1:0]  mask_shamt;
  logic [RawW-1:0]  mask;
  logic [DataW-1:0] intel_bits;
  logic [DataW-1:0] moto_bits;
  logic [RawW-1:0]  field;
  logic [4:0]       sign_idx;
  logic             field_msb;
  logic             len_bad;

  // Clamp the byte count and derive frame size in bits
  assign nbytes = (frame_length_i > MaxBytes) ? MaxBytes : frame_length_i;
  assign nbits  = {nbytes[3:0], 3'b000};

  // Intel: contiguous slice from the start bit
  assign intel_end  = {1'b0, cfg_i.first_bit} + {1'b0, cfg_i.field_length};
  assign intel_bits = frame_data_i >> cfg_i.first_bit;

  // Motorola: sawtooth order is linear once bits inside a byte are mirrored,
  // and the gathered field is then a slice of the byte-swapped word
  assign moto_first = {1'b0, cfg_i.first_bit[5:3], ~cfg_i.first_bit[2:0]};
  assign moto_last  = moto_first + {1'b0, cfg_i.field_length} - 7'd1;
  assign moto_shamt = 7'd64 - moto_first - {1'b0, cfg_i.field_length};
  assign moto_bits  = byte_swap(frame_data_i) >> moto_shamt;

  // Field mask for 1..32 bits
  assign mask_shamt = MaxField - cfg_i.field_length;
  assign mask       = {RawW{1'b1}} >> mask_shamt[4:0];

  assign len_bad = (cfg_i.field_length == '0) || (cfg_i.field_length > MaxField);

  // Checks in priority order
  always_comb begin
    if (frame_id_i != cfg_i.signal_id) begin
      status_o = ST_ID_MISMATCH;
    end else if (len_bad) begin
      status_o = ST_BAD_LENGTH;
    end else if ({1'b0, cfg_i.first_bit} >= nbits) begin
      status_o = ST_OUT_OF_FRAME;
    end else if (cfg_i.little_endian && (intel_end > nbits)) begin
      status_o = ST_OUT_OF_FRAME;
    end else if (!cfg_i.little_endian && ({1'b0, moto_last[6:3]} >= {1'b0, nbytes})) begin
      status_o = ST_OUT_OF_FRAME;
    end else begin
      status_o = ST_DECODED;
    end
  end

  // Select the byte order and apply the mask
  assign field     = (cfg_i.little_endian ? intel_bits[RawW-1:0] : moto_bits[RawW-1:0]) & mask;
  assign sign_idx  = 5'(cfg_i.field_length - 6'd1);
  assign field_msb = field[sign_idx];

  // Zero the outputs unless decoded; sign-extend on request
  always_comb begin
    if (status_o != ST_DECODED) begin
      raw_o   = '0;
      value_o = '0;
    end else begin
      raw_o = field;
      if (cfg_i.signed_field && field_msb) begin
        value_o = $signed({1'b1, field | ~mask});
      end else begin
        value_o = $signed({1'b0, field});
      end
    end
  end

endmodule

@@ design/cansd_scale.sv @@
// Scaling pipeline: registered multiply, then add offset with saturation.
// Depends on cansd_pkg; owns the last two pipeline stages and the output register.
module cansd_scale import cansd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  status_e                    status_i,
  input  logic [RawW-1:0]            raw_i,
  input  logic signed [RawW:0]       value_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output status_e                    status_o,
  output logic [RawW-1:0]            raw_o,
  output logic signed [ResultW-1:0]  scaled_o
);

  logic                       mul_valid_q;
  status_e                    mul_status_q;
  logic [RawW-1:0]            mul_raw_q;
  logic signed [ResultW-1:0]  prod_q;
  logic signed [ResultW:0]    prod_full;
  logic signed [ResultW:0]    sum;
  logic signed [ResultW-1:0]  sum_sat;
  logic                       out_valid_q;
  status_e                    out_status_q;
  logic [RawW-1:0]            out_raw_q;
  logic signed [ResultW-1:0]  out_scaled_q;
  logic                       out_en;
  logic                       mul_en;

  // Advance a stage when it is empty or the next one moves
  assign out_en  = !out_valid_q || ready_i;
  assign mul_en  = !mul_valid_q || out_en;
  assign ready_o = mul_en;

  // Multiply raw value by the Q16.16 factor
  assign prod_full = value_i * cfg_i.scale_factor;

  // Add offset and clamp to the signed 64-bit range
  assign sum = {prod_q[ResultW-1], prod_q}
             + {{(ResultW+1-ScaleW){cfg_i.scale_offset[ScaleW-1]}}, cfg_i.scale_offset};
  always_comb begin
    if (sum[ResultW] != sum[ResultW-1]) begin
      sum_sat = sum[ResultW] ? {1'b1, {(ResultW-1){1'b0}}} : {1'b0, {(ResultW-1){1'b1}}};
    end else begin
      sum_sat = sum[ResultW-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_en) mul_valid_q <= valid_i;
      if (out_en) out_valid_q <= mul_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en && valid_i) begin
      mul_status_q <= status_i;
      mul_raw_q    <= raw_i;
      prod_q       <= prod_full[ResultW-1:0];
    end
    if (out_en && mul_valid_q) begin
      out_status_q <= mul_status_q;
      out_raw_q    <= mul_raw_q;
      out_scaled_q <= (mul_status_q == ST_DECODED) ? sum_sat : '0;
    end
  end

  assign valid_o  = out_valid_q;
  assign status_o = out_status_q;
  assign raw_o    = out_raw_q;
  assign scaled_o = out_scaled_q;

endmodule

@@ design/can_signal_decoder.sv @@
// Throughput: one frame per cycle while the master side takes results; stages are input
// register, field gather, multiply, offset add/saturate into the output register.
// Backpressure stalls only the stages behind a full one.
// Reset clears all stage valid bits and loads the register defaults.
// Top level of the CAN signal decoder; depends on cansd_pkg, cansd_cfg_regs,
// cansd_extract and cansd_scale.
module can_signal_decoder import cansd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i,
  // Frame input
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // frame_id[28:0], frame_length[32:29], frame_data[96:33], zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // Decoded result
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // raw_value[31:0], scaled_value[95:32]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // status[1:0], zero pad
  output logic [OutTuserW-1:0] m_axis_tuser_o
);

  cfg_t                      cfg;
  logic                      in_valid_q;
  logic [IdW-1:0]            in_id_q;
  logic [LenW-1:0]           in_len_q;
  logic [DataW-1:0]          in_data_q;
  status_e                   ex_status;
  logic [RawW-1:0]           ex_raw;
  logic signed [RawW:0]      ex_value;
  logic                      ex_valid_q;
  status_e                   ex_status_q;
  logic [RawW-1:0]           ex_raw_q;
  logic signed [RawW:0]      ex_value_q;
  logic                      sc_ready;
  logic                      ex_en;
  logic                      in_en;
  status_e                   out_status;
  logic [RawW-1:0]           out_raw;
  logic signed [ResultW-1:0] out_scaled;

  assign cfg_ready_o = 1'b1;

  cansd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage enables
  assign ex_en           = !ex_valid_q || sc_ready;
  assign in_en           = !in_valid_q || ex_en;
  assign s_axis_tready_o = in_en;

  // Input and extract registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ex_valid_q <= 1'b0;
    end else begin
      if (in_en) in_valid_q <= s_axis_tvalid_i;
      if (ex_en) ex_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid_i) begin
      in_id_q   <= s_axis_tdata_i[28:0];
      in_len_q  <= s_axis_tdata_i[32:29];
      in_data_q <= s_axis_tdata_i[96:33];
    end
    if (ex_en && in_valid_q) begin
      ex_status_q <= ex_status;
      ex_raw_q    <= ex_raw;
      ex_value_q  <= ex_value;
    end
  end

  cansd_extract u_extract (
    .cfg_i          (cfg),
    .frame_id_i     (in_id_q),
    .frame_length_i (in_len_q),
    .frame_data_i   (in_data_q),
    .status_o       (ex_status),
    .raw_o          (ex_raw),
    .value_o        (ex_value)
  );

  cansd_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (ex_valid_q),
    .ready_o  (sc_ready),
    .status_i (ex_status_q),
    .raw_i    (ex_raw_q),
    .value_i  (ex_value_q),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .status_o (out_status),
    .raw_o    (out_raw),
    .scaled_o (out_scaled)
  );

  // Pack the result
  assign m_axis_tdata_o = {out_scaled, out_raw};
  assign m_axis_tuser_o = {{(OutTuserW-2){1'b0}}, out_status};

`ifndef ASSERT_OFF
  // Items in flight change only by input and output transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({in_valid_q, ex_valid_q, u_scale.mul_valid_q, m_axis_tvalid_o}) ==
      $past($countones({in_valid_q, ex_valid_q, u_scale.mul_valid_q, m_axis_tvalid_o}))
      + 3'($past(s_axis_tvalid_i && s_axis_tready_o))
      - 3'($past(m_axis_tvalid_o && m_axis_tready_i)))
    else $error("pipeline occupancy does not match transfers");

  // A result that is not decoded carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status != ST_DECODED) |-> (out_raw == '0 && out_scaled == '0))
    else $error("undecoded result carries nonzero data");

  // A zero raw field scales to the offset alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status == ST_DECODED && out_raw == '0) |->
      (out_scaled == ResultW'(cfg.scale_offset)))
    else $error("zero raw field did not scale to the offset");

  // Unsigned gathered value agrees with raw bits in the extract register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_valid_q && ex_status_q == ST_DECODED && !cfg.signed_field) |->
      (ex_value_q == $signed({1'b0, ex_raw_q})))
    else $error("unsigned field value differs from raw bits");
`endif

endmodule

@@ tb/can_signal_decoder_checker.sv @@
`timescale 1ns / 100ps
// Checker for the CAN signal decoder: follows the register writes, predicts one
// decoded result per accepted frame and compares it with each result transfer.
// Depends on cansd_pkg for widths, register indexes and status codes.
module can_signal_decoder_checker import cansd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  // frame_id[28:0], frame_length[32:29], frame_data[96:33], zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  // raw_value[31:0], scaled_value[95:32]
  input  logic [OutTdataW-1:0] m_axis_tdata_i,
  // status[1:0], zero pad
  input  logic [OutTuserW-1:0] m_axis_tuser_i,
  output int                   pending_o,
  output int                   errors_o
);

  typedef struct {
    status_e                   status;
    logic [RawW-1:0]           raw;
    logic signed [ResultW-1:0] scaled;
  } decoded_t;

  cfg_t     sig_cfg;
  decoded_t decoded_q[$];
  int       fails = 0;

  assign errors_o = fails;

  // Gather the configured field from one frame and scale it
  function automatic decoded_t decode_frame(cfg_t c, logic [IdW-1:0] fid,
                                            logic [LenW-1:0] flen,
                                            logic [DataW-1:0] fdata);
    decoded_t                  d;
    int unsigned               nbits;
    int unsigned               pos;
    int unsigned               width;
    logic [RawW-1:0]           raw;
    logic [DataW-1:0]          slice;
    longint                    value;
    logic signed [ResultW+1:0] sum;
    d.status = ST_DECODED;
    d.raw    = '0;
    d.scaled = '0;
    raw      = '0;
    nbits    = (flen > MaxBytes) ? 64 : 8 * flen;
    width    = c.field_length;
    if (fid != c.signal_id) begin
      d.status = ST_ID_MISMATCH;
    end else if (width == 0 || width > MaxField) begin
      d.status = ST_BAD_LENGTH;
    end else if (c.first_bit >= nbits) begin
      d.status = ST_OUT_OF_FRAME;
    end else if (c.little_endian) begin
      if (c.first_bit + width > nbits) begin
        d.status = ST_OUT_OF_FRAME;
      end else begin
        slice = (fdata >> c.first_bit) & ((64'd1 << width) - 64'd1);
        raw   = slice[RawW-1:0];
      end
    end else begin
      // Motorola order: MSB first, sawtooth through the bytes
      pos = c.first_bit;
      for (int i = 0; i < width && d.status == ST_DECODED; i++) begin
        if (pos >= nbits) begin
          d.status = ST_OUT_OF_FRAME;
        end else begin
          raw = {raw[RawW-2:0], fdata[pos]};
          pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
        end
      end
    end
    if (d.status == ST_DECODED) begin
      value = longint'(raw);
      if (c.signed_field && raw[width-1]) begin
        value = value - (longint'(1) << width);
      end
      sum = value * c.scale_factor + c.scale_offset;
      // Clamp to the signed 64-bit range
      if (sum[ResultW+1:ResultW-1] != {3{sum[ResultW-1]}}) begin
        d.scaled = sum[ResultW+1] ? {1'b1, {(ResultW-1){1'b0}}}
                                  : {1'b0, {(ResultW-1){1'b1}}};
      end else begin
        d.scaled = sum[ResultW-1:0];
      end
      d.raw = raw;
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    decoded_t got;
    if (!rst_ni) begin
      sig_cfg <= '{signal_id: RstSignalId, first_bit: RstStartBit,
                   field_length: RstFieldLength, little_endian: RstLittleEnd,
                   signed_field: RstSignedField, scale_factor: RstScaleFactor,
                   scale_offset: RstScaleOffset};
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SIGNAL_ID:     sig_cfg.signal_id     <= cfg_data_i[IdW-1:0];
          CFG_START_BIT:     sig_cfg.first_bit     <= cfg_data_i[BitW-1:0];
          CFG_FIELD_LENGTH:  sig_cfg.field_length  <= cfg_data_i[BitW-1:0];
          CFG_LITTLE_ENDIAN: sig_cfg.little_endian <= cfg_data_i[0];
          CFG_SIGNED_FIELD:  sig_cfg.signed_field  <= cfg_data_i[0];
          CFG_SCALE_FACTOR:  sig_cfg.scale_factor  <= $signed(cfg_data_i);
          CFG_SCALE_OFFSET:  sig_cfg.scale_offset  <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      // Predict on each frame transfer
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        decoded_q.push_back(decode_frame(sig_cfg, s_axis_tdata_i[IdW-1:0],
                                         s_axis_tdata_i[IdW+LenW-1:IdW],
                                         s_axis_tdata_i[IdW+LenW+DataW-1:IdW+LenW]));
      end
      // Compare each result transfer with the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = status_e'(m_axis_tuser_i[1:0]);
        got.raw    = m_axis_tdata_i[RawW-1:0];
        got.scaled = $signed(m_axis_tdata_i[RawW+ResultW-1:RawW]);
        if (decoded_q.size() == 0) begin
          $error("result transfer with no frame outstanding");
          fails++;
        end else begin
          want = decoded_q.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %s, got %s", want.status.name(), got.status.name());
            fails++;
          end
          if (got.raw != want.raw) begin
            $error("raw_value: expected %h, got %h", want.raw, got.raw);
            fails++;
          end
          if (got.scaled != want.scaled) begin
            $error("scaled_value: expected %0d, got %0d", want.scaled, got.scaled);
            fails++;
          end
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

@@ tb/can_signal_decoder_tb.sv @@
`timescale 1ns / 100ps
// Top of the CAN signal decoder testbench: clock, reset, register programming,
// frame stimulus and result backpressure. Depends on cansd_pkg, the decoder
// and can_signal_decoder_checker, which does all prediction and comparison.
module can_signal_decoder_tb;
  import cansd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int PadW       = InTdataW - IdW - LenW - DataW;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDatW-1:0]   cfg_data = '0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [InTdataW-1:0]  s_data = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutTdataW-1:0] m_data;
  logic [OutTuserW-1:0] m_user;

  int pending;
  int errors;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  can_signal_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  can_signal_decoder_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("can_signal_decoder test failed");
      $finish;
    end
  end

  // Result backpressure: random stalls, plus one long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready   <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_ready   <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic cfg_t make_signal(logic [IdW-1:0] id, logic [BitW-1:0] sb,
                                       logic [BitW-1:0] len, logic le, logic sg,
                                       logic [ScaleW-1:0] factor,
                                       logic [ScaleW-1:0] offset);
    cfg_t c;
    c.signal_id     = id;
    c.first_bit     = sb;
    c.field_length  = len;
    c.little_endian = le;
    c.signed_field  = sg;
    c.scale_factor  = factor;
    c.scale_offset  = offset;
    return c;
  endfunction

  function automatic logic [ScaleW-1:0] random_q16();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly decodable signals, with invalid widths and edge values mixed in
  function automatic cfg_t random_signal();
    logic [IdW-1:0]  id;
    logic [BitW-1:0] len;
    logic [BitW-1:0] sb;
    logic            le;
    case ($urandom_range(7))
      0:       id = '0;
      1:       id = '1;
      default: id = IdW'($urandom);
    endcase
    if ($urandom_range(9) != 0) len = BitW'($urandom_range(1, 32));
    else len = BitW'($urandom_range(2) == 0 ? 0 : $urandom_range(33, 63));
    le = 1'($urandom);
    if (le && len <= MaxField && $urandom_range(3) != 0)
      sb = BitW'($urandom_range(0, 64 - len));
    else
      sb = BitW'($urandom_range(63));
    return make_signal(id, sb, len, le, 1'($urandom), random_q16(), random_q16());
  endfunction

  // Let every outstanding result arrive, then allow the pipeline to settle
  task automatic wait_results();
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram the whole signal description while the block is idle
  task automatic program_signal(cfg_t c);
    s_valid <= 1'b0;
    wait_results();
    write_reg(CFG_SIGNAL_ID,     CfgDatW'(c.signal_id));
    write_reg(CFG_START_BIT,     CfgDatW'(c.first_bit));
    write_reg(CFG_FIELD_LENGTH,  CfgDatW'(c.field_length));
    write_reg(CFG_LITTLE_ENDIAN, CfgDatW'(c.little_endian));
    write_reg(CFG_SIGNED_FIELD,  CfgDatW'(c.signed_field));
    write_reg(CFG_SCALE_FACTOR,  c.scale_factor);
    write_reg(CFG_SCALE_OFFSET,  c.scale_offset);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(logic [IdW-1:0] fid, logic [LenW-1:0] flen,
                            logic [DataW-1:0] fdata);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{PadW{1'b0}}, fdata, flen, fid};
    do @(posedge clk); while (!s_ready);
  endtask

  function automatic logic [DataW-1:0] random_data();
    return {$urandom, $urandom};
  endfunction

  initial begin
    cfg_t sig;
    int   n_frames;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: id 0, Intel byte 0, unsigned, unity scale
    send_frame('0, 4'd8, '1);
    send_frame('0, 4'd15, 64'h0123_4567_89AB_CDA5);
    send_frame(29'd1, 4'd8, random_data());
    send_frame('1, 4'd8, random_data());
    send_frame('0, 4'd0, random_data());
    send_frame('0, 4'd1, 64'hFFFF_FFFF_FFFF_FF7F);

    // Zero width; identifier is checked before width
    program_signal(make_signal('1, 6'd0, 6'd0, 1'b1, 1'b0, 32'h0001_0000, '0));
    send_frame('1, 4'd8, random_data());
    send_frame(29'h0AAA_AAAA, 4'd8, random_data());
    program_signal(make_signal('1, 6'd0, 6'd33, 1'b1, 1'b0, 32'h0001_0000, '0));
    send_frame('1, 4'd8, random_data());
    // Width is checked before the frame bounds
    program_signal(make_signal('1, 6'd63, 6'd63, 1'b0, 1'b1, 32'h0001_0000, '0));
    send_frame('1, 4'd2, random_data());

    // Signed full-width Intel field at the upper word, extreme scaling
    program_signal(make_signal(29'h155, 6'd32, 6'd32, 1'b1, 1'b1,
                               32'h8000_0000, 32'h7FFF_FFFF));
    send_frame(29'h155, 4'd8, 64'h8000_0000_1234_5678);
    send_frame(29'h155, 4'd8, 64'hFFFF_FFFF_0000_0000);
    send_frame(29'h155, 4'd8, 64'h7FFF_FFFF_FFFF_FFFF);
    send_frame(29'h155, 4'd7, random_data());

    // Motorola 16-bit field from bit 7 over bytes 0 and 1
    program_signal(make_signal('0, 6'd7, 6'd16, 1'b0, 1'b0,
                               32'h7FFF_FFFF, 32'h8000_0000));
    send_frame('0, 4'd2, 64'h0000_0000_0000_A55A);
    send_frame('0, 4'd1, random_data());
    send_frame('0, 4'd8, '1);

    // Motorola field that wraps to the next byte from its lowest bit
    program_signal(make_signal('0, 6'd0, 6'd16, 1'b0, 1'b1, 32'h0001_0000, 32'hFFFF_0000));
    send_frame('0, 4'd2, random_data());
    send_frame('0, 4'd3, random_data());
    program_signal(make_signal('0, 6'd63, 6'd1, 1'b0, 1'b0, 32'h0000_8000, '0));
    send_frame('0, 4'd8, 64'h8000_0000_0000_0000);
    send_frame('0, 4'd7, random_data());
    program_signal(make_signal('0, 6'd56, 6'd32, 1'b0, 1'b0, 32'h0001_0000, '0));
    send_frame('0, 4'd8, random_data());

    // Random signals under each idling pattern
    for (int phase = 0; phase < 21; phase++) begin
      sig = random_signal();
      program_signal(sig);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      // Long result hold-off while frames keep coming
      if (phase == 4) begin
        sender_idle_pct = 0;
        hold_go <= 1'b1;
      end
      n_frames = $urandom_range(36, 44);
      for (int k = 0; k < n_frames; k++) begin
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(9) < 7) send_frame(sig.signal_id, 4'd8, random_data());
          else send_frame(sig.signal_id, LenW'($urandom_range(15)), random_data());
        end else begin
          send_frame(IdW'($urandom), LenW'($urandom_range(15)), random_data());
        end
      end
    end

    s_valid <= 1'b0;
    wait_results();
    if (errors == 0) begin
      $display("can_signal_decoder test passed");
    end else begin
      $display("can_signal_decoder test failed");
    end
    $finish;
  end

endmodule
